// ----- hw/rtl/bud_pkg.sv -----
// ----------------------------------------------------------------------------
// bud_pkg
// Shared types and constants of the byte unstuffing deframer.
// ----------------------------------------------------------------------------
package bud_pkg;

	localparam int MAX_FRAME_BYTES = 4096;
	localparam int BYTE_W          = 8;
	localparam int COUNT_W         = 13;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 13;
	localparam int Q_DEPTH         = 2;
	localparam int Q_PTR_W         = 1;
	localparam int Q_CNT_W         = 2;

	localparam logic [BYTE_W-1:0]  START_MARKER_RST  = 8'd161;
	localparam logic [BYTE_W-1:0]  END_MARKER_RST    = 8'd162;
	localparam logic [BYTE_W-1:0]  ESCAPE_MARKER_RST = 8'd163;
	localparam logic [COUNT_W-1:0] LENGTH_LIMIT_RST  = 13'd4096;

	localparam logic FUNC_DATA      = 1'b0;
	localparam logic FUNC_NEW_FRAME = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MARKER,
		CFG_END_MARKER,
		CFG_ESCAPE_MARKER,
		CFG_LENGTH_LIMIT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_ENDED,
		ST_BAD,
		ST_RESTART,
		ST_NOSPACE
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  start_marker;
		logic [BYTE_W-1:0]  end_marker;
		logic [BYTE_W-1:0]  escape_marker;
		logic [COUNT_W-1:0] length_limit;
	} cfg_t;

	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] in_byte;
	} in_item_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] in_byte;
		logic              is_start;
		logic              is_end;
		logic              is_esc;
		logic              inv_is_marker;
	} q_entry_t;

	typedef struct packed {
		status_t            status;
		logic               consumed;
		logic               out_valid;
		logic [BYTE_W-1:0]  out_byte;
		logic [COUNT_W-1:0] frame_length;
		logic               waiting_start;
		logic               frame_ended;
		logic               frame_bad;
	} out_item_t;

endpackage

// ----- hw/rtl/bud_ifs.sv -----
// ----------------------------------------------------------------------------
// bud channel interfaces
// Input stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface bud_in_if;
	logic              valid;
	logic              ready;
	bud_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bud_out_if;
	logic               valid;
	logic               ready;
	bud_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bud_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [bud_pkg::CFG_IDX_W-1:0]        index;
	logic [bud_pkg::CFG_DATA_W-1:0]       wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/bud_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bud_cfg_regs
// Marker and length limit registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module bud_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	bud_cfg_if.sink       cfg,
	output bud_pkg::cfg_t regs
);

	bud_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_marker  <= bud_pkg::START_MARKER_RST;
			regs_q.end_marker    <= bud_pkg::END_MARKER_RST;
			regs_q.escape_marker <= bud_pkg::ESCAPE_MARKER_RST;
			regs_q.length_limit  <= bud_pkg::LENGTH_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (bud_pkg::cfg_idx_t'(cfg.index))
				bud_pkg::CFG_START_MARKER: begin
					regs_q.start_marker <= cfg.wdata[bud_pkg::BYTE_W-1:0];
				end
				bud_pkg::CFG_END_MARKER: begin
					regs_q.end_marker <= cfg.wdata[bud_pkg::BYTE_W-1:0];
				end
				bud_pkg::CFG_ESCAPE_MARKER: begin
					regs_q.escape_marker <= cfg.wdata[bud_pkg::BYTE_W-1:0];
				end
				bud_pkg::CFG_LENGTH_LIMIT: begin
					regs_q.length_limit <= cfg.wdata[bud_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/bud_front.sv -----
// ----------------------------------------------------------------------------
// bud_front
// Accepts input transactions and tags each byte against the markers.
// ----------------------------------------------------------------------------
module bud_front (
	bud_in_if.sink             src,
	input  bud_pkg::cfg_t      regs,
	input  logic               q_full,
	output logic               push,
	output bud_pkg::q_entry_t  push_data
);

	logic [bud_pkg::BYTE_W-1:0] inv_byte;

	assign src.ready = !q_full;
	assign push      = src.valid && !q_full;
	assign inv_byte  = ~src.data.in_byte;

	always_comb begin
		push_data.func          = src.data.func;
		push_data.in_byte       = src.data.in_byte;
		push_data.is_start      = (src.data.in_byte == regs.start_marker);
		push_data.is_end        = (src.data.in_byte == regs.end_marker);
		push_data.is_esc        = (src.data.in_byte == regs.escape_marker);
		// complemented byte after an escape must name one of the markers
		push_data.inv_is_marker = (inv_byte == regs.start_marker) ||
		                          (inv_byte == regs.end_marker) ||
		                          (inv_byte == regs.escape_marker);
	end

endmodule

// ----- hw/rtl/bud_queue.sv -----
// ----------------------------------------------------------------------------
// bud_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bud_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bud_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_vld,
	output bud_pkg::q_entry_t head
);

	bud_pkg::q_entry_t                 mem_q [bud_pkg::Q_DEPTH];
	logic [bud_pkg::Q_PTR_W-1:0]       wr_ptr_q;
	logic [bud_pkg::Q_PTR_W-1:0]       rd_ptr_q;
	logic [bud_pkg::Q_CNT_W-1:0]       cnt_q;

	assign full     = (cnt_q == bud_pkg::Q_CNT_W'(bud_pkg::Q_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bud_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bud_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + bud_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - bud_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/bud_back.sv -----
// ----------------------------------------------------------------------------
// bud_back
// Frame state machine: decodes queued items and registers one result each.
// ----------------------------------------------------------------------------
module bud_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bud_pkg::cfg_t     regs,
	input  logic              head_vld,
	input  bud_pkg::q_entry_t head,
	output logic              pop,
	bud_out_if.source         dst
);

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_RAW,
		PH_NEG,
		PH_END,
		PH_FAIL
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic [bud_pkg::COUNT_W-1:0]   count_q, count_d;
	logic [bud_pkg::COUNT_W-1:0]   limit;
	logic                          no_room;
	bud_pkg::out_item_t            res;
	bud_pkg::out_item_t            res_q;
	logic                          res_vld_q;

	assign limit = (regs.length_limit > bud_pkg::COUNT_W'(bud_pkg::MAX_FRAME_BYTES)) ?
	               bud_pkg::COUNT_W'(bud_pkg::MAX_FRAME_BYTES) : regs.length_limit;
	assign no_room = (count_q >= limit);

	// advance when the output register is free or being drained
	assign pop       = head_vld && (!res_vld_q || dst.ready);
	assign dst.valid = res_vld_q;
	assign dst.data  = res_q;

	always_comb begin
		phase_d       = phase_q;
		count_d       = count_q;
		res           = '0;
		res.status    = bud_pkg::ST_OK;
		if (head.func == bud_pkg::FUNC_NEW_FRAME) begin
			count_d = '0;
			phase_d = PH_WAIT;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					res.consumed = 1'b1;
					count_d      = '0;
					if (head.is_start) begin
						phase_d = PH_RAW;
					end else begin
						phase_d    = PH_FAIL;
						res.status = bud_pkg::ST_BAD;
					end
				end
				PH_RAW: begin
					if (head.is_start) begin
						res.consumed = 1'b1;
						count_d      = '0;
						res.status   = bud_pkg::ST_RESTART;
					end else if (head.is_end) begin
						res.consumed = 1'b1;
						if (count_q == '0) begin
							phase_d    = PH_FAIL;
							res.status = bud_pkg::ST_BAD;
						end else begin
							phase_d    = PH_END;
							res.status = bud_pkg::ST_ENDED;
						end
					end else if (head.is_esc) begin
						res.consumed = 1'b1;
						phase_d      = PH_NEG;
					end else if (no_room) begin
						res.status = bud_pkg::ST_NOSPACE;
					end else begin
						res.consumed  = 1'b1;
						res.out_valid = 1'b1;
						res.out_byte  = head.in_byte;
						count_d       = count_q + bud_pkg::COUNT_W'(1);
					end
				end
				PH_NEG: begin
					if (head.is_start) begin
						res.consumed = 1'b1;
						count_d      = '0;
						phase_d      = PH_RAW;
						res.status   = bud_pkg::ST_RESTART;
					end else if (head.is_end || head.is_esc) begin
						res.consumed = 1'b1;
						phase_d      = PH_FAIL;
						res.status   = bud_pkg::ST_BAD;
					end else if (no_room) begin
						res.status = bud_pkg::ST_NOSPACE;
					end else begin
						res.consumed = 1'b1;
						if (head.inv_is_marker) begin
							res.out_valid = 1'b1;
							res.out_byte  = ~head.in_byte;
							count_d       = count_q + bud_pkg::COUNT_W'(1);
							phase_d       = PH_RAW;
						end else begin
							phase_d    = PH_FAIL;
							res.status = bud_pkg::ST_BAD;
						end
					end
				end
				PH_END: begin
					res.status = bud_pkg::ST_ENDED;
				end
				default: begin
					phase_d    = PH_FAIL;
					res.status = bud_pkg::ST_BAD;
				end
			endcase
		end
		res.frame_length  = count_d;
		res.waiting_start = (phase_d == PH_WAIT);
		res.frame_ended   = (phase_d == PH_END);
		res.frame_bad     = (phase_d == PH_FAIL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			count_q   <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_d;
				count_q   <= count_d;
				res_vld_q <= 1'b1;
			end else if (dst.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	a_wait_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> count_q == '0)
		else $error("frame count nonzero while waiting for start");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bud_pkg::COUNT_W'(bud_pkg::MAX_FRAME_BYTES))
		else $error("frame count above maximum frame size");

	a_nospace_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res.status == bud_pkg::ST_NOSPACE |=>
		$stable(count_q) && $stable(phase_q))
		else $error("out-of-space result changed the frame state");

	a_decode_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.out_valid |-> res_q.consumed &&
		res_q.status == bud_pkg::ST_OK)
		else $error("decoded byte without a consumed input");

endmodule

// ----- hw/rtl/byte_unstuff_deframer.sv -----
// ----------------------------------------------------------------------------
// byte_unstuff_deframer
// Byte unstuffing deframer with start, end and escape markers.
// ----------------------------------------------------------------------------
// One stuffed byte or new-frame command is taken per clock while the queue is
// not full, and each yields exactly one result transaction carrying status,
// the decoded byte if any and the frame state after that item. Sustained rate
// is one item per cycle while the output is ready; the frame state machine in
// the back end updates phase and byte count as it pops each item. A result
// passes through the two-entry queue and then the output register. The input
// side keeps accepting while a result waits at the output until the queue is
// full. Configuration writes are registered and are meant for idle periods.
module byte_unstuff_deframer (
	input  logic      clk,
	input  logic      arst_n,
	bud_in_if.sink    src,
	bud_out_if.source dst,
	bud_cfg_if.sink   cfg
);

	bud_pkg::cfg_t     regs;
	logic              q_full;
	logic              push;
	bud_pkg::q_entry_t push_data;
	logic              pop;
	logic              head_vld;
	bud_pkg::q_entry_t head;

	bud_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bud_front u_front (
		.src       (src),
		.regs      (regs),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	bud_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_vld  (head_vld),
		.head      (head)
	);

	bud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop),
		.dst      (dst)
	);

endmodule
